/* sv/fra_pkg.sv */
package fra_pkg;

  localparam int SIZE_W          = 25;
  localparam int ALIGN_W         = 17;
  localparam int FRAME_W         = 32;
  localparam int STATUS_W        = 2;
  localparam int OFFSET_BITS     = 24;
  localparam int MAX_RECORDS_DEF = 128;

  localparam int END_W  = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
  localparam int POS_W  = END_W + 1;
  localparam int ITER_W = $clog2(END_W);

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = SIZE_W'(65536);

  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_FINALIZE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [SIZE_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  alignment;
    logic [FRAME_W-1:0]  frame_number;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [OFFSET_BITS-1:0] offset;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_TOP,
    ST_ALLOC_END,
    ST_ALLOC_EVAL,
    ST_ALIGN,
    ST_COMMIT,
    ST_FIN_READ,
    ST_FIN_CHECK,
    ST_RESPOND
  } state_t;

endpackage

/* sv/frame_ring_allocator.sv */
// Ring allocator over a byte heap of heap_size bytes, keeping a FIFO of up to MAX_RECORDS
// allocation records (frame tag, offset, size) in on-chip memory. An allocate request takes
// request_size + alignment bytes after the newest record's end, or from offset 0 when the ring
// has not wrapped, and returns the aligned offset or a no-space / queue-full status. A finalize
// request drops the oldest records tagged before its frame_number and makes that the current
// frame. One request is handled at a time; req_ready is high only while the sequencer is idle,
// and the response register lets the next request in while a response waits. Allocate steps
// through ALLOC_TOP, ALLOC_END (a registered read of the newest record), ALLOC_EVAL, then
// ALIGN in the bit-serial remainder unit when the alignment is not a power of two and the
// base is nonzero, then COMMIT and RESPOND; a failure skips COMMIT, and an empty ring goes
// from ALLOC_TOP to COMMIT or RESPOND. Finalize loops FIN_READ, FIN_CHECK, a registered
// read and compare per record, until one stays or none is left; RESPOND waits on res_ready.
// heap_size may be written only while the block is idle.
module frame_ring_allocator #(
  parameter int MAX_RECORDS = fra_pkg::MAX_RECORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [fra_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  fra_pkg::request_t          req,
  output logic                       res_valid,
  input  logic                       res_ready,
  output fra_pkg::result_t           res
);
  import fra_pkg::*;

  localparam int SLOT_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam logic [SUM_W-1:0]  MAX_SUM   = SUM_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_RECORDS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_RECORDS - 1);

  logic [FRAME_W-1:0]     rec_frame  [MAX_RECORDS];
  logic [OFFSET_BITS-1:0] rec_offset [MAX_RECORDS];
  logic [SIZE_W-1:0]      rec_size   [MAX_RECORDS];

  state_t                 state, state_next;
  logic [SIZE_W-1:0]      heap_size;
  logic [SLOT_W-1:0]      oldest;
  logic [CNT_W-1:0]       count;
  logic [FRAME_W-1:0]     current_frame;
  request_t               cur;
  logic [OFFSET_BITS-1:0] top;
  logic [END_W-1:0]       base;
  logic [END_W-1:0]       v_sh;
  logic [ALIGN_W-1:0]     rem;
  logic [ITER_W-1:0]      iter;
  logic [STATUS_W-1:0]    pend_status;
  logic [OFFSET_BITS-1:0] pend_offset;
  logic [FRAME_W-1:0]     rd_frame;
  logic [OFFSET_BITS-1:0] rd_off;
  logic [SIZE_W-1:0]      rd_size;
  logic [SLOT_W-1:0]      rd_addr;

  logic [SUM_W-1:0]   sum_wr, sum_new;
  logic [SLOT_W-1:0]  wr_slot, new_slot, oldest_inc;
  logic [END_W-1:0]   need, end_val, top_ext, heap_ext, end_space, start_space, sel_base;
  logic               wrapped, fit_end, fit_start, heap_short, queue_full, fin_pop, res_free;
  logic [ALIGN_W-1:0] align_eff, align_mask;
  logic               is_pow2;
  logic [ALIGN_W:0]   rem_sh;
  logic               rem_ge;
  logic [POS_W-1:0]   pos_pow2, pos_rem, pos_full;
  logic [OFFSET_BITS-1:0] pos;
  logic               mem_we;

  assign sum_wr     = SUM_W'(oldest) + SUM_W'(count);
  assign wr_slot    = (sum_wr >= MAX_SUM) ? SLOT_W'(sum_wr - MAX_SUM) : SLOT_W'(sum_wr);
  assign sum_new    = sum_wr - SUM_W'(1);
  assign new_slot   = (sum_new >= MAX_SUM) ? SLOT_W'(sum_new - MAX_SUM) : SLOT_W'(sum_new);
  assign oldest_inc = (oldest == LAST_SLOT) ? '0 : oldest + SLOT_W'(1);

  assign need     = END_W'(cur.request_size) + END_W'(cur.alignment);
  assign end_val  = END_W'(rd_off) + END_W'(rd_size);
  assign top_ext  = END_W'(top);
  assign heap_ext = END_W'(heap_size);
  assign wrapped  = !(top_ext < end_val);

  always_comb begin
    if (!wrapped) begin
      end_space   = (heap_ext > end_val) ? heap_ext - end_val : '0;
      start_space = top_ext;
    end else begin
      end_space   = top_ext - end_val;
      start_space = '0;
    end
  end

  assign fit_end    = end_space >= need;
  assign fit_start  = start_space >= need;
  assign sel_base   = fit_end ? end_val : '0;
  assign heap_short = need > heap_ext;
  assign queue_full = count >= MAX_CNT;

  assign align_eff  = (cur.alignment == '0) ? ALIGN_W'(1) : cur.alignment;
  assign align_mask = align_eff - ALIGN_W'(1);
  assign is_pow2    = (align_eff & align_mask) == '0;
  assign rem_sh     = {rem, v_sh[END_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, align_eff};

  assign pos_pow2 = (POS_W'(base) + POS_W'(align_mask)) & ~POS_W'(align_mask);
  assign pos_rem  = POS_W'(base) + ((rem == '0) ? '0 : POS_W'(align_eff - rem));
  assign pos_full = is_pow2 ? pos_pow2 : pos_rem;
  assign pos      = pos_full[OFFSET_BITS-1:0];

  assign fin_pop  = rd_frame < cur.frame_number;
  assign res_free = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    rd_addr    = oldest;
    req_ready  = 1'b0;
    mem_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = (req.operation == OP_FINALIZE) ? ST_FIN_READ : ST_ALLOC_TOP;
        end
      end
      ST_ALLOC_TOP: begin
        if (count == '0) begin
          state_next = heap_short ? ST_RESPOND : ST_COMMIT;
        end else begin
          state_next = ST_ALLOC_END;
        end
      end
      ST_ALLOC_END: begin
        rd_addr    = new_slot;
        state_next = ST_ALLOC_EVAL;
      end
      ST_ALLOC_EVAL: begin
        if ((!fit_end && !fit_start) || queue_full) begin
          state_next = ST_RESPOND;
        end else if (is_pow2 || sel_base == '0) begin
          state_next = ST_COMMIT;
        end else begin
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (iter == '0) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        mem_we     = 1'b1;
        state_next = ST_RESPOND;
      end
      ST_FIN_READ: begin
        state_next = (count == '0 || cur.frame_number == '0) ? ST_RESPOND : ST_FIN_CHECK;
      end
      ST_FIN_CHECK: begin
        state_next = fin_pop ? ST_FIN_READ : ST_RESPOND;
      end
      ST_RESPOND: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      heap_size     <= HEAP_SIZE_RESET;
      oldest        <= '0;
      count         <= '0;
      current_frame <= '0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        heap_size <= cfg_wr_data;
      end
      if (mem_we) begin
        count <= count + CNT_W'(1);
      end
      if (state == ST_FIN_CHECK && fin_pop) begin
        oldest <= oldest_inc;
        count  <= count - CNT_W'(1);
      end
      if ((state == ST_FIN_READ || state == ST_FIN_CHECK) && state_next == ST_RESPOND) begin
        current_frame <= cur.frame_number;
      end
      if (state == ST_RESPOND && res_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      cur <= req;
    end
    case (state)
      ST_ALLOC_TOP: begin
        base <= '0;
        rem  <= '0;
        if (heap_short && count == '0) begin
          pend_status <= STATUS_NO_SPACE;
          pend_offset <= '0;
        end
      end
      ST_ALLOC_END: begin
        top <= rd_off;
      end
      ST_ALLOC_EVAL: begin
        base <= sel_base;
        v_sh <= sel_base;
        rem  <= '0;
        iter <= ITER_W'(END_W - 1);
        pend_offset <= '0;
        if (!fit_end && !fit_start) begin
          pend_status <= STATUS_NO_SPACE;
        end else if (queue_full) begin
          pend_status <= STATUS_QUEUE_FULL;
        end
      end
      ST_ALIGN: begin
        rem  <= rem_ge ? ALIGN_W'(rem_sh - {1'b0, align_eff}) : ALIGN_W'(rem_sh);
        v_sh <= v_sh << 1;
        iter <= iter - ITER_W'(1);
      end
      ST_COMMIT: begin
        pend_status <= STATUS_OK;
        pend_offset <= pos;
      end
      ST_FIN_READ, ST_FIN_CHECK: begin
        pend_status <= STATUS_OK;
        pend_offset <= '0;
      end
      default: begin
      end
    endcase
    if (state == ST_RESPOND && res_free) begin
      res.status <= pend_status;
      res.offset <= pend_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rec_frame[wr_slot]  <= current_frame;
      rec_offset[wr_slot] <= pos;
      rec_size[wr_slot]   <= cur.request_size;
    end
    rd_frame <= rec_frame[rd_addr];
    rd_off   <= rec_offset[rd_addr];
    rd_size  <= rec_size[rd_addr];
  end

endmodule

/* sv/fra_checker.sv */
module fra_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input fra_pkg::request_t req,
  input logic              res_valid,
  input logic              res_ready,
  input fra_pkg::result_t  res
);
  import fra_pkg::*;

  a_res_clear_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("response valid after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after a request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.status == STATUS_OK || res.status == STATUS_NO_SPACE ||
                   res.status == STATUS_QUEUE_FULL))
    else $error("unknown status code");

  a_fail_offset_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != STATUS_OK |-> res.offset == '0)
    else $error("nonzero offset on failure");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled response changed");

endmodule

bind frame_ring_allocator fra_checker u_fra_checker (.*);
